// ===== sv/glos_pkg.sv =====
// Shared widths and register indexes for the grid line-of-sight checker.
// No dependencies; the top level imports it.
package glos_pkg;

  localparam int COORD_W = 21;   // obstacle edge, unsigned fixed point
  localparam int CELL_W  = 7;    // grid column or row
  localparam int SLOT_W  = 6;    // obstacle table entry of a load
  localparam int PITCH_W = 4;
  localparam int RANGE_W = 9;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_PITCH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSING_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_COUNT = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

// ===== sv/grid_line_of_sight_check.sv =====
// Grid line-of-sight checker: obstacle table in one synchronous memory and the
// query engine that scans it. Depends on glos_pkg.
//
// Usage: a load item (in_tuser = 0) writes one rectangle into the obstacle table
// and gives no result, and the block stays ready for the next item. A query
// item (in_tuser = 1) names an observer and a target cell and gives one result
// item with visible, target_blocked and out_of_range. Two setup states
// (ST_SETUP, ST_RANGE) form the cell centres, the sensing window and the range
// test; then the table memory is read one entry per cycle through a three-stage
// pipe (read, multiply, accumulate), paced by the single read port of the table.
// The block takes the next item while a result still waits in the output
// register. The sightline test works on signs of the cross products; touching
// and collinear contact count as blocked. Table entries hold no reset value:
// keep obstacle_count at or below the number of entries loaded.
module grid_line_of_sight_check
  import glos_pkg::*;
#(
  parameter int GRID_CELLS    = 128,
  parameter int MAX_OBSTACLES = 64,
  parameter int FRACTION_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // obstacle_slot, edge_left, edge_right, edge_bottom, edge_top,
  // observer_x, observer_y, target_x, target_y (from bit 0 up), zero filled
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // visible, target_blocked, out_of_range (from bit 0 up), zero filled
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [RANGE_W-1:0]     cfg_wdata
);

  localparam int AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CW  = 8 + PITCH_W + FRACTION_BITS - 1;       // centre width
  localparam int VW  = ((CW > COORD_W) ? CW : COORD_W) + 2;   // signed coordinates
  localparam int MW  = 13;                                    // signed step * pitch
  localparam int PW  = MW + VW;                               // cross product term
  localparam int SQW = 2 * MW;
  localparam int EW  = 4 * COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_RANGE, ST_SCAN, ST_DONE
  } state_t;

  // Configuration registers
  logic [PITCH_W-1:0] pitch_r;
  logic [RANGE_W-1:0] range_r;
  logic [COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= PITCH_W'(4);
      range_r <= RANGE_W'(40);
      count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_PITCH:     pitch_r <= cfg_wdata[PITCH_W-1:0];
        CFG_SENSING_RANGE:  range_r <= cfg_wdata;
        CFG_OBSTACLE_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [SLOT_W-1:0]  f_slot;
  logic [EW-1:0]      f_edges;
  logic [CELL_W-1:0]  f_ox, f_oy, f_tx, f_ty;
  assign f_slot  = in_tdata[5:0];
  assign f_edges = {in_tdata[89:69], in_tdata[68:48], in_tdata[47:27], in_tdata[26:6]};
  assign f_ox    = in_tdata[96:90];
  assign f_oy    = in_tdata[103:97];
  assign f_tx    = in_tdata[110:104];
  assign f_ty    = in_tdata[117:111];

  state_t state_r, state_nxt;
  logic   in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Obstacle table: {top, bottom, right, left} per entry
  logic [EW-1:0] mem [MAX_OBSTACLES];
  logic [EW-1:0] rd_q;
  logic [8:0]    slot_ext;
  logic          wr_en, rd_en;
  logic [AW:0]   k_r, n_r;

  assign slot_ext = 9'(f_slot);
  assign wr_en    = in_acc && (in_tuser == ACT_LOAD) && (slot_ext < 9'(MAX_OBSTACLES));

  always_ff @(posedge clk) begin
    if (wr_en) mem[slot_ext[AW-1:0]] <= f_edges;
    if (rd_en) rd_q <= mem[k_r[AW-1:0]];
  end

  // Query registers
  logic [CELL_W-1:0]   ox_r, oy_r, tx_r, ty_r;
  logic signed [7:0]   dx_r, dy_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic [CW-1:0]       px_r, py_r, qx_r, qy_r;
  logic signed [VW-1:0] wl_r, wh_r, wb_r, wt_r;
  logic                far_r, blocked_r, clear_r;
  logic                v1_r, v2_r;
  logic signed [PW-1:0] al_r, ar_r, bb_r, bt_r;
  logic                ov_r, hit_r;
  logic [3:0]          qc_r;
  logic                out_valid_r;
  logic [2:0]          out_flags_r;

  // Setup logic
  logic signed [7:0]    dxc, dyc;
  logic signed [MW-1:0] mxc, myc;
  logic [11:0]          cpx, cpy, cqx, cqy;
  logic signed [VW-1:0] pxs, pys, rsh;
  logic [MW-1:0]        amx, amy;
  logic [7:0]           adx, ady;
  logic signed [SQW-1:0] sq;
  logic [2*RANGE_W-1:0] rsq;
  logic                 off_grid, far_box;
  logic [AW:0]          n_c;

  assign dxc = $signed({1'b0, tx_r}) - $signed({1'b0, ox_r});
  assign dyc = $signed({1'b0, ty_r}) - $signed({1'b0, oy_r});
  assign mxc = dxc * $signed({1'b0, pitch_r});
  assign myc = dyc * $signed({1'b0, pitch_r});
  assign cpx = {ox_r, 1'b1} * pitch_r;
  assign cpy = {oy_r, 1'b1} * pitch_r;
  assign cqx = {tx_r, 1'b1} * pitch_r;
  assign cqy = {ty_r, 1'b1} * pitch_r;

  assign pxs = $signed(VW'(px_r));
  assign pys = $signed(VW'(py_r));
  assign rsh = $signed(VW'(range_r) << FRACTION_BITS);
  assign amx = mx_r[MW-1] ? MW'(-mx_r) : MW'(mx_r);
  assign amy = my_r[MW-1] ? MW'(-my_r) : MW'(my_r);
  assign adx = dx_r[7] ? 8'(-dx_r) : 8'(dx_r);
  assign ady = dy_r[7] ? 8'(-dy_r) : 8'(dy_r);
  assign sq  = mx_r * mx_r + my_r * my_r;
  assign rsq = range_r * range_r;
  assign off_grid = (8'(tx_r) >= 8'(GRID_CELLS)) || (8'(ty_r) >= 8'(GRID_CELLS));
  // |d| > range / pitch is the same as |d| * pitch > range for integers
  assign far_box = (pitch_r == '0)
                 ? ((9'(adx) > 9'(GRID_CELLS)) || (9'(ady) > 9'(GRID_CELLS)))
                 : ((amx > MW'(range_r)) || (amy > MW'(range_r)));
  assign n_c = (9'(count_r) > 9'(MAX_OBSTACLES)) ? (AW+1)'(MAX_OBSTACLES)
                                                  : (AW+1)'(count_r);

  // Stage 1: entry from the table
  logic [COORD_W-1:0]   xl, xh, yl, yh;
  logic signed [VW-1:0] xls, xhs, yls, yhs;
  logic signed [VW-1:0] dxl, dxh, dyl, dyh;
  logic                 ovx, ovy, hit;
  logic [3:0]           qc;

  assign xl = rd_q[COORD_W-1:0];
  assign xh = rd_q[2*COORD_W-1:COORD_W];
  assign yl = rd_q[3*COORD_W-1:2*COORD_W];
  assign yh = rd_q[4*COORD_W-1:3*COORD_W];
  assign xls = $signed(VW'(xl));
  assign xhs = $signed(VW'(xh));
  assign yls = $signed(VW'(yl));
  assign yhs = $signed(VW'(yh));
  assign dxl = xls - pxs;
  assign dxh = xhs - pxs;
  assign dyl = yls - pys;
  assign dyh = yhs - pys;

  assign hit = (CW'(xl) <= qx_r) && (qx_r <= CW'(xh)) &&
               (CW'(yl) <= qy_r) && (qy_r <= CW'(yh));
  // Strict endpoint overlap with the sensing window
  assign ovx = (wl_r < xls && xls < wh_r) || (wl_r < xhs && xhs < wh_r) ||
               (xls < wl_r && wl_r < xhs) || (xls < wh_r && wh_r < xhs);
  assign ovy = (wb_r < yls && yls < wt_r) || (wb_r < yhs && yhs < wt_r) ||
               (yls < wb_r && wb_r < yhs) || (yls < wt_r && wt_r < yhs);
  // Edge-line side test: the two centres must not lie strictly on one side
  assign qc[0] = (yh == yl) || !((px_r > CW'(xl) && qx_r > CW'(xl)) ||
                                 (px_r < CW'(xl) && qx_r < CW'(xl)));
  assign qc[1] = (yh == yl) || !((px_r > CW'(xh) && qx_r > CW'(xh)) ||
                                 (px_r < CW'(xh) && qx_r < CW'(xh)));
  assign qc[2] = (xh == xl) || !((py_r > CW'(yl) && qy_r > CW'(yl)) ||
                                 (py_r < CW'(yl) && qy_r < CW'(yl)));
  assign qc[3] = (xh == xl) || !((py_r > CW'(yh) && qy_r > CW'(yh)) ||
                                 (py_r < CW'(yh) && qy_r < CW'(yh)));

  // Stage 2: corner sides of the sightline
  logic signed [PW:0] d_lb, d_lt, d_rb, d_rt;
  logic               touch;

  assign d_lb = (PW+1)'(bb_r) - (PW+1)'(al_r);
  assign d_lt = (PW+1)'(bt_r) - (PW+1)'(al_r);
  assign d_rb = (PW+1)'(bb_r) - (PW+1)'(ar_r);
  assign d_rt = (PW+1)'(bt_r) - (PW+1)'(ar_r);

  function automatic logic straddle(input logic signed [PW:0] a, input logic signed [PW:0] b);
    straddle = !((a > 0 && b > 0) || (a < 0 && b < 0));
  endfunction

  assign touch = ov_r && ((straddle(d_lb, d_lt) && qc_r[0]) ||
                          (straddle(d_rb, d_rt) && qc_r[1]) ||
                          (straddle(d_lb, d_rb) && qc_r[2]) ||
                          (straddle(d_lt, d_rt) && qc_r[3]));

  assign rd_en = (state_r == ST_SCAN) && (k_r < n_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_tuser == ACT_QUERY) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_RANGE;
      ST_RANGE: state_nxt = ST_SCAN;
      ST_SCAN:  if (!rd_en && !v1_r && !v2_r) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= rd_en;
      v2_r    <= v1_r;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      // load the result once the output register is free or being taken, and free the engine
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_flags_r <= {far_r, blocked_r, !far_r && !blocked_r && clear_r};
      end
    end

    if (in_acc) begin
      ox_r <= f_ox;
      oy_r <= f_oy;
      tx_r <= f_tx;
      ty_r <= f_ty;
    end

    if (state_r == ST_SETUP) begin
      dx_r <= dxc;
      dy_r <= dyc;
      mx_r <= mxc;
      my_r <= myc;
      px_r <= CW'(cpx) << (FRACTION_BITS - 1);
      py_r <= CW'(cpy) << (FRACTION_BITS - 1);
      qx_r <= CW'(cqx) << (FRACTION_BITS - 1);
      qy_r <= CW'(cqy) << (FRACTION_BITS - 1);
      n_r  <= n_c;
    end

    if (state_r == ST_RANGE) begin
      wl_r      <= pxs - rsh;
      wh_r      <= pxs + rsh;
      wb_r      <= pys - rsh;
      wt_r      <= pys + rsh;
      far_r     <= off_grid || far_box || (sq > $signed(SQW'(rsq)));
      k_r       <= '0;
      blocked_r <= 1'b0;
      clear_r   <= 1'b1;
    end

    if (rd_en) k_r <= k_r + 1'b1;

    // multiply stage
    if (v1_r) begin
      al_r  <= my_r * dxl;
      ar_r  <= my_r * dxh;
      bb_r  <= mx_r * dyl;
      bt_r  <= mx_r * dyh;
      ov_r  <= ovx && ovy;
      qc_r  <= qc;
      hit_r <= hit;
    end

    // accumulate stage
    if (v2_r) begin
      if (hit_r) blocked_r <= 1'b1;
      if (touch) clear_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_flags_r};

endmodule
